>>> hdl/dpq_pkg.sv
`timescale 1ns / 1ps

package dpq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W     = 1;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int KEY_W    = MONTH_W + DAY_W;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OP_W-1:0] OP_PULL   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             ins_en;
    logic             pull_en;
    logic [KEY_W-1:0] key;
  } dpq_cmd_t;

endpackage

>>> hdl/dpq_if.sv
`timescale 1ns / 1ps

interface dpq_in_if import dpq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [DAY_W-1:0]   day;
  logic [MONTH_W-1:0] month;

  modport source (output valid, opcode, day, month, input ready);
  modport sink   (input valid, opcode, day, month, output ready);
endinterface

interface dpq_out_if import dpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DAY_W-1:0]    out_day;
  logic [MONTH_W-1:0]  out_month;
  logic [COUNT_W-1:0]  count;
  logic                is_empty;

  modport source (output valid, status, out_day, out_month, count, is_empty, input ready);
  modport sink   (input valid, status, out_day, out_month, count, is_empty, output ready);
endinterface

>>> hdl/dpq_cell.sv
`timescale 1ns / 1ps

module dpq_cell import dpq_pkg::*; (
  input  logic             clk_i,
  input  dpq_cmd_t         cmd_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [CNT_W-1:0] index_i,
  input  logic [KEY_W-1:0] prev_key_i,
  input  logic             prev_le_i,
  input  logic [KEY_W-1:0] next_key_i,
  output logic [KEY_W-1:0] key_o,
  output logic             le_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic             occ;

  assign occ   = index_i < count_i;
  assign le_o  = occ && (key_q <= cmd_i.key);
  assign key_o = key_q;

  // on insert keep entries up to the insertion point, take the new key there, shift up beyond it; on pull shift down
  always_comb begin
    key_d = key_q;
    if (cmd_i.ins_en) begin
      if (!le_o) begin
        key_d = prev_le_i ? cmd_i.key : prev_key_i;
      end
    end else if (cmd_i.pull_en) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

>>> hdl/date_priority_queue.sv
`timescale 1ns / 1ps
// The result of an item is registered and valid in the cycle after the item is accepted.
// Throughput: one insert or pull per cycle while results are taken; every cell of
// the chain compares its key with the new date in parallel, so the next item
// depends only on that one registered update of the cells.
// Reset clears the entry count and the result valid flag; stored dates and result fields are not cleared.

module date_priority_queue import dpq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dpq_in_if.sink     in_i,
  dpq_out_if.source  out_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [DAY_W-1:0]    day_q, day_d;
  logic [MONTH_W-1:0]  month_q, month_d;

  logic     accept, full, empty;
  dpq_cmd_t cmd;

  logic [KEY_W-1:0] cell_key [CAPACITY];
  logic             cell_le  [CAPACITY];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = count_q >= CNT_W'(CAPACITY);
  assign empty      = count_q == '0;

  assign cmd.key     = {in_i.month, in_i.day};
  assign cmd.ins_en  = accept && (in_i.opcode == OP_INSERT) && !full;
  assign cmd.pull_en = accept && (in_i.opcode == OP_PULL) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] prev_key, next_key;
    logic             prev_le;

    if (i == 0) begin : g_head
      assign prev_key = '0;
      assign prev_le  = 1'b1;
    end else begin : g_body
      assign prev_key = cell_key[i-1];
      assign prev_le  = cell_le[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key = '0;
    end else begin : g_mid
      assign next_key = cell_key[i+1];
    end

    dpq_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .count_i    (count_q),
      .index_i    (CNT_W'(i)),
      .prev_key_i (prev_key),
      .prev_le_i  (prev_le),
      .next_key_i (next_key),
      .key_o      (cell_key[i]),
      .le_o       (cell_le[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    day_d    = day_q;
    month_d  = month_q;
    if (accept) begin
      status_d = ST_OK;
      day_d    = '0;
      month_d  = '0;
      if (in_i.opcode == OP_INSERT) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
          day_d   = cell_key[0][DAY_W-1:0];
          month_d = cell_key[0][KEY_W-1:DAY_W];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    day_q    <= day_d;
    month_q  <= month_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = status_q;
  assign out_o.out_day   = day_q;
  assign out_o.out_month = month_q;
  assign out_o.count     = COUNT_W'(count_q);
  assign out_o.is_empty  = empty;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item gave no result");

  a_pull_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.opcode == OP_PULL) && empty |=> status_q == ST_EMPTY && count_q == '0)
    else $error("pull on empty queue not flagged");

  a_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.opcode == OP_INSERT) && full |=> status_q == ST_FULL && $stable(count_q))
    else $error("insert on full queue not flagged");

endmodule

>>> dv/dpq_checker.sv
`timescale 1ns / 1ps

module dpq_checker import dpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dpq_in_if    in_i,
  dpq_out_if   out_i,
  output int   fail_cnt_o,
  output int   pending_o
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DAY_W-1:0]    out_day;
    logic [MONTH_W-1:0]  out_month;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } dpq_res_t;

  logic [KEY_W-1:0] date_store[$];
  dpq_res_t         due_results[$];
  int               mismatches = 0;
  int               waiting    = 0;

  assign fail_cnt_o = mismatches;
  assign pending_o  = waiting;

  function automatic dpq_res_t apply_to_store(logic [OP_W-1:0] op, logic [DAY_W-1:0] day,
                                              logic [MONTH_W-1:0] month);
    dpq_res_t         res;
    logic [KEY_W-1:0] key;
    int               pos;
    res        = '0;
    res.status = ST_OK;
    key        = {month, day};
    if (op == OP_INSERT) begin
      if (date_store.size() >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // place after every stored date that is less than or equal
        pos = 0;
        while (pos < date_store.size() && date_store[pos] <= key) pos++;
        date_store.insert(pos, key);
      end
    end else if (date_store.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      key           = date_store.pop_front();
      res.out_day   = key[DAY_W-1:0];
      res.out_month = key[KEY_W-1:DAY_W];
    end
    res.count    = COUNT_W'(date_store.size());
    res.is_empty = (date_store.size() == 0);
    return res;
  endfunction

  task automatic report(string msg);
    mismatches++;
    $display("[%0t] dpq mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dpq_res_t got;
    dpq_res_t want;
    if (!rst_ni) begin
      date_store.delete();
      due_results.delete();
      waiting = 0;
    end else begin
      // compare the result first: it belongs to an item accepted earlier
      if (out_i.valid && out_i.ready) begin
        got = '{out_i.status, out_i.out_day, out_i.out_month, out_i.count, out_i.is_empty};
        if (due_results.size() == 0) begin
          report($sformatf("result with nothing outstanding, status %0d count %0d",
                           got.status, got.count));
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status)
            report($sformatf("status got %0d expected %0d", got.status, want.status));
          if (got.out_day !== want.out_day)
            report($sformatf("out_day got %0d expected %0d", got.out_day, want.out_day));
          if (got.out_month !== want.out_month)
            report($sformatf("out_month got %0d expected %0d", got.out_month,
                             want.out_month));
          if (got.count !== want.count)
            report($sformatf("count got %0d expected %0d", got.count, want.count));
          if (got.is_empty !== want.is_empty)
            report($sformatf("is_empty got %0d expected %0d", got.is_empty,
                             want.is_empty));
        end
      end
      if (in_i.valid && in_i.ready)
        due_results.push_back(apply_to_store(in_i.opcode, in_i.day, in_i.month));
      waiting = due_results.size();
    end
  end

endmodule

>>> dv/tb_date_priority_queue.sv
`timescale 1ns / 1ps

module tb_date_priority_queue import dpq_pkg::*; ();

  localparam int IDLE_LIMIT   = 200;
  localparam int RANDOM_ITEMS = 700;
  localparam int PHASE_LEN    = 50;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int   idle_cycles = 0;
  bit   steady      = 1'b0;

  dpq_in_if  in_if ();
  dpq_out_if out_if ();

  date_priority_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  dpq_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_i      (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic offer_date(logic [OP_W-1:0] op, logic [DAY_W-1:0] day,
                            logic [MONTH_W-1:0] month);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.day    <= day;
    in_if.month  <= month;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // mostly calendar dates, some from a narrow set to force equal keys, some raw bits
  task automatic pick_date(output logic [DAY_W-1:0] day, output logic [MONTH_W-1:0] month);
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      day   = DAY_W'($urandom_range(1, 31));
      month = MONTH_W'($urandom_range(1, 12));
    end else if (mode < 8) begin
      day   = DAY_W'($urandom_range(1, 3));
      month = MONTH_W'($urandom_range(1, 2));
    end else begin
      day   = DAY_W'($urandom);
      month = MONTH_W'($urandom);
    end
  endtask

  // result side: stall a random number of cycles before taking each item, except in steady phases
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_date_priority_queue NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                 bias;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    bias          = 50;
    in_if.valid  <= 1'b0;
    in_if.opcode <= OP_INSERT;
    in_if.day    <= '0;
    in_if.month  <= '0;
    rst_ni       <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pull on empty, then fill to capacity with extremes and equal keys
    offer_date(OP_PULL, 5'd31, 4'd15);
    offer_date(OP_INSERT, 5'd31, 4'd15);
    offer_date(OP_INSERT, 5'd0, 4'd0);
    offer_date(OP_INSERT, 5'd1, 4'd1);
    offer_date(OP_INSERT, 5'd31, 4'd12);
    offer_date(OP_INSERT, 5'd15, 4'd6);
    offer_date(OP_INSERT, 5'd15, 4'd6);
    offer_date(OP_INSERT, 5'd14, 4'd6);
    offer_date(OP_INSERT, 5'd16, 4'd6);
    offer_date(OP_INSERT, 5'd1, 4'd12);
    offer_date(OP_INSERT, 5'd31, 4'd1);
    offer_date(OP_INSERT, 5'd10, 4'd3);
    offer_date(OP_INSERT, 5'd10, 4'd3);
    offer_date(OP_INSERT, 5'd5, 4'd9);
    offer_date(OP_INSERT, 5'd28, 4'd2);
    offer_date(OP_INSERT, 5'd30, 4'd11);
    offer_date(OP_INSERT, 5'd20, 4'd8);
    // full now: both inserts must bounce
    offer_date(OP_INSERT, 5'd7, 4'd7);
    offer_date(OP_INSERT, 5'd0, 4'd0);
    offer_date(OP_PULL, 5'd0, 4'd0);
    offer_date(OP_PULL, 5'd17, 4'd9);
    offer_date(OP_PULL, 5'd0, 4'd0);
    offer_date(OP_PULL, 5'd31, 4'd15);

    // phases lean towards inserts or pulls, or are balanced, so that full and empty are both reached
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0:       bias = 20;
          1:       bias = 50;
          default: bias = 85;
        endcase
        steady = ($urandom_range(0, 3) == 0);
      end
      pick_date(day, month);
      offer_date(($urandom_range(0, 99) < bias) ? OP_INSERT : OP_PULL, day, month);
    end
    in_if.valid <= 1'b0;
    steady = 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_date_priority_queue OK");
    end else begin
      $display("tb_date_priority_queue NOT OK");
    end
    $finish;
  end

endmodule

>>> date_priority_queue.f
hdl/dpq_pkg.sv
hdl/dpq_if.sv
hdl/dpq_cell.sv
hdl/date_priority_queue.sv
dv/dpq_checker.sv
dv/tb_date_priority_queue.sv
